// ===== rtl/tnp_pkg.sv =====
// Shared types and constants for the ternary neuron popcount block.
// No dependencies; used by the interfaces, tnp_accum and the top level.
package tnp_pkg;

  localparam int THR_W = 13;
  localparam int SUM_OUT_W = 13;
  localparam int VAL_W = 2;

  typedef logic signed [THR_W-1:0] thr_t;
  typedef logic signed [SUM_OUT_W-1:0] sum_out_t;

  typedef enum logic [VAL_W-1:0] {
    VAL_ZERO  = 2'd0,
    VAL_PLUS  = 2'd1,
    VAL_MINUS = 2'd2
  } val_t;

  typedef struct packed {
    logic valid;
    logic last;
  } word_ctl_t;

endpackage

// ===== rtl/tnp_if.sv =====
// Valid/ready channel interfaces: word requests, results, threshold writes.
// Depends on tnp_pkg.
interface tnp_word_if #(parameter int WORD_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] act_plus;
  logic [WORD_BITS-1:0] act_minus;
  logic [WORD_BITS-1:0] weight_plus;
  logic [WORD_BITS-1:0] weight_minus;
  logic                 last_word;

  modport source (output valid, act_plus, act_minus, weight_plus, weight_minus, last_word,
                  input ready);
  modport sink (input valid, act_plus, act_minus, weight_plus, weight_minus, last_word,
                output ready);
endinterface

interface tnp_result_if;
  logic                       valid;
  logic                       ready;
  tnp_pkg::sum_out_t          neuron_sum;
  logic [tnp_pkg::VAL_W-1:0]  neuron_value;

  modport source (output valid, neuron_sum, neuron_value, input ready);
  modport sink (input valid, neuron_sum, neuron_value, output ready);
endinterface

interface tnp_cfg_if;
  logic          valid;
  logic          ready;
  tnp_pkg::thr_t threshold;

  modport source (output valid, threshold, input ready);
  modport sink (input valid, threshold, output ready);
endinterface

// ===== rtl/tnp_popdiff.sv =====
// Agree-minus-disagree popcount of one registered word, as two adder trees.
// Depends on no package items.
module tnp_popdiff #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]                     act_plus,
  input  logic [WORD_BITS-1:0]                     act_minus,
  input  logic [WORD_BITS-1:0]                     weight_plus,
  input  logic [WORD_BITS-1:0]                     weight_minus,
  output logic signed [$clog2(WORD_BITS+1):0]      diff
);

  localparam int CNT_W = $clog2(WORD_BITS + 1);
  localparam int LV = $clog2(WORD_BITS);
  localparam int P = 1 << LV;

  logic [WORD_BITS-1:0] agree_bits;
  logic [WORD_BITS-1:0] differ_bits;
  logic [CNT_W-1:0] agree_lvl [LV+1][P];
  logic [CNT_W-1:0] differ_lvl [LV+1][P];

  assign agree_bits = (act_plus & weight_plus) | (act_minus & weight_minus);
  assign differ_bits = (act_plus & weight_minus) | (act_minus & weight_plus);

  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int i = 0; i < P; i++) begin
        agree_lvl[l][i] = '0;
        differ_lvl[l][i] = '0;
      end
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      agree_lvl[0][i] = CNT_W'(agree_bits[i]);
      differ_lvl[0][i] = CNT_W'(differ_bits[i]);
    end
    for (int l = 1; l <= LV; l++) begin
      for (int i = 0; i < (P >> l); i++) begin
        agree_lvl[l][i] = agree_lvl[l-1][2*i] + agree_lvl[l-1][2*i+1];
        differ_lvl[l][i] = differ_lvl[l-1][2*i] + differ_lvl[l-1][2*i+1];
      end
    end
  end

  assign diff = $signed({1'b0, agree_lvl[LV][0]}) - $signed({1'b0, differ_lvl[LV][0]});

endmodule

// ===== rtl/tnp_accum.sv =====
// Saturating running sum, threshold decision and result register.
// Depends on tnp_pkg and tnp_result_if.
module tnp_accum #(
  parameter int WORD_BITS = 32,
  parameter int MAX_WORDS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tnp_pkg::word_ctl_t                     ctl,
  input  logic signed [$clog2(WORD_BITS+1):0]    diff,
  input  tnp_pkg::thr_t                          threshold,
  output logic                                   go,
  tnp_result_if.source                           results
);

  localparam int SUM_BOUND = WORD_BITS * MAX_WORDS;
  localparam int SW = $clog2(SUM_BOUND + 1) + 1;
  localparam int DW = $clog2(WORD_BITS + 1) + 1;
  localparam int XW = (SW > DW ? SW : DW) + 1;
  localparam int CW = (SW > tnp_pkg::THR_W + 1) ? SW : tnp_pkg::THR_W + 1;
  localparam logic signed [XW-1:0] BOUND_POS = XW'(SUM_BOUND);
  localparam logic signed [XW-1:0] BOUND_NEG = -XW'(SUM_BOUND);

  logic signed [SW-1:0] running_sum;
  logic signed [SW-1:0] running_sum_next;
  logic signed [XW-1:0] raw_sum;
  logic signed [SW-1:0] sat_sum;
  logic signed [CW-1:0] cmp_sum;
  logic signed [CW-1:0] cmp_thr;
  tnp_pkg::val_t        value;

  assign go = ctl.valid && (!ctl.last || !results.valid || results.ready);

  always_comb begin
    raw_sum = XW'(running_sum) + XW'(diff);
    if (raw_sum > BOUND_POS) begin
      sat_sum = SW'(BOUND_POS);
    end else if (raw_sum < BOUND_NEG) begin
      sat_sum = SW'(BOUND_NEG);
    end else begin
      sat_sum = SW'(raw_sum);
    end
    cmp_sum = CW'(sat_sum);
    cmp_thr = CW'(threshold);
    priority if (cmp_sum >= cmp_thr) begin
      value = tnp_pkg::VAL_PLUS;
    end else if (cmp_sum <= -cmp_thr) begin
      value = tnp_pkg::VAL_MINUS;
    end else begin
      value = tnp_pkg::VAL_ZERO;
    end
    running_sum_next = running_sum;
    if (go) begin
      running_sum_next = ctl.last ? '0 : sat_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      results.valid <= 1'b0;
    end else begin
      running_sum <= running_sum_next;
      if (go && ctl.last) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctl.last) begin
      results.neuron_sum <= tnp_pkg::SUM_OUT_W'(sat_sum);
      results.neuron_value <= value;
    end
  end

`ifndef SYNTHESIS
  a_sum_bounded: assert property (@(posedge clk) disable iff (rst)
    (XW'(running_sum) <= BOUND_POS) && (XW'(running_sum) >= BOUND_NEG))
    else $error("running sum outside saturation bound");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    go && ctl.last |=> running_sum == '0)
    else $error("running sum not cleared after last word");

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    go && ctl.last |=> results.valid)
    else $error("last word gave no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |-> !(go && ctl.last))
    else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/ternary_neuron_popcount_threshold.sv =====
// Top level of the ternary neuron: input register, threshold register, datapath.
// Depends on tnp_pkg, tnp_if, tnp_popdiff and tnp_accum.
//
//  channel   modport  payload                                            
//  words     sink     act_plus, act_minus, weight_plus, weight_minus, last_word
//  results   source   neuron_sum, neuron_value (one per last word)
//  cfg       sink     threshold (always ready)
//
// One word is taken per cycle while no held result stalls a last word.
// The popcount trees and saturating add sit between input and result registers.
// Reset (rst, synchronous) clears the running sum, threshold and valid flags.
// A stalled result stalls the next last word and the words behind it; earlier words keep accumulating.
module ternary_neuron_popcount_threshold #(
  parameter int WORD_BITS = 32,
  parameter int MAX_WORDS = 64
) (
  input  logic         clk,
  input  logic         rst,
  tnp_word_if.sink     words,
  tnp_result_if.source results,
  tnp_cfg_if.sink      cfg
);

  localparam int DW = $clog2(WORD_BITS + 1) + 1;

  logic [WORD_BITS-1:0] act_plus;
  logic [WORD_BITS-1:0] act_minus;
  logic [WORD_BITS-1:0] weight_plus;
  logic [WORD_BITS-1:0] weight_minus;
  tnp_pkg::word_ctl_t   ctl;
  tnp_pkg::thr_t        threshold;
  logic signed [DW-1:0] diff;
  logic                 go;

  assign words.ready = !ctl.valid || go;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
      ctl.last <= 1'b0;
      threshold <= '0;
    end else begin
      if (words.ready) begin
        ctl.valid <= words.valid;
      end
      if (words.valid && words.ready) begin
        ctl.last <= words.last_word;
      end
      if (cfg.valid) begin
        threshold <= cfg.threshold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      act_plus <= words.act_plus;
      act_minus <= words.act_minus;
      weight_plus <= words.weight_plus;
      weight_minus <= words.weight_minus;
    end
  end

  tnp_popdiff #(
    .WORD_BITS(WORD_BITS)
  ) u_popdiff (
    .act_plus(act_plus),
    .act_minus(act_minus),
    .weight_plus(weight_plus),
    .weight_minus(weight_minus),
    .diff(diff)
  );

  tnp_accum #(
    .WORD_BITS(WORD_BITS),
    .MAX_WORDS(MAX_WORDS)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .diff(diff),
    .threshold(threshold),
    .go(go),
    .results(results)
  );

endmodule

// ===== bench/tb_ternary_neuron_popcount_threshold.sv =====
// Self-checking bench for ternary_neuron_popcount_threshold: word, result and threshold channels.
// Depends on tnp_pkg, the tnp_if interfaces and the rtl top level.
// A neuron sum tracker class predicts each neuron result and checks the DUT output against it.
`timescale 1ns / 100ps

module tb_ternary_neuron_popcount_threshold;

  localparam int WORD_BITS = 32;
  localparam int MAX_WORDS = 64;
  localparam int SUM_BOUND = WORD_BITS * MAX_WORDS;
  localparam int RANDOM_WORDS = 1700;
  localparam int CALM_AFTER = 1450;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TIMEOUT_NS = 5000000;

  typedef logic [WORD_BITS-1:0] mask_t;

  typedef enum int {
    MIX_RANDOM,
    MIX_SPARSE,
    MIX_PROPER,
    MIX_AGREE,
    MIX_DISAGREE
  } word_mix_t;

  typedef struct {
    tnp_pkg::sum_out_t sum;
    tnp_pkg::val_t     value;
  } neuron_out_t;

  class neuron_sum_tracker;
    tnp_pkg::thr_t threshold;
    int            running_sum;
    neuron_out_t   pending_neurons[$];
    int            errors;
    int            words_seen;
    int            results_seen;
    int            clamp_count;

    function new();
      threshold = '0;
      running_sum = 0;
      errors = 0;
      words_seen = 0;
      results_seen = 0;
      clamp_count = 0;
    endfunction

    function void set_threshold(tnp_pkg::thr_t t);
      threshold = t;
    endfunction

    function void take_word(mask_t ap, mask_t am, mask_t wp, mask_t wm, logic last);
      int          agree;
      int          differ;
      int          s;
      neuron_out_t want;
      agree = $countones((ap & wp) | (am & wm));
      differ = $countones((ap & wm) | (am & wp));
      s = running_sum + agree - differ;
      if (s > SUM_BOUND) begin
        s = SUM_BOUND;
        clamp_count++;
      end
      if (s < -SUM_BOUND) begin
        s = -SUM_BOUND;
        clamp_count++;
      end
      running_sum = s;
      words_seen++;
      if (last) begin
        want.sum = tnp_pkg::sum_out_t'(s);
        if (s >= int'(threshold)) begin
          want.value = tnp_pkg::VAL_PLUS;
        end else if (s <= -int'(threshold)) begin
          want.value = tnp_pkg::VAL_MINUS;
        end else begin
          want.value = tnp_pkg::VAL_ZERO;
        end
        pending_neurons.push_back(want);
        running_sum = 0;
      end
    endfunction

    function void check_neuron(tnp_pkg::sum_out_t got_sum,
                               logic [tnp_pkg::VAL_W-1:0] got_value);
      neuron_out_t want;
      if (pending_neurons.size() == 0) begin
        $error("unexpected result: neuron_sum %0d neuron_value %0d", got_sum, got_value);
        errors++;
        return;
      end
      want = pending_neurons.pop_front();
      results_seen++;
      if (got_sum !== want.sum) begin
        $error("neuron_sum: expected %0d, actual %0d", want.sum, got_sum);
        errors++;
      end
      if (got_value !== want.value) begin
        $error("neuron_value: expected %0d, actual %0d", want.value, got_value);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  tnp_word_if #(.WORD_BITS(WORD_BITS)) word_ch ();
  tnp_result_if result_ch ();
  tnp_cfg_if cfg_ch ();

  ternary_neuron_popcount_threshold #(
    .WORD_BITS(WORD_BITS),
    .MAX_WORDS(MAX_WORDS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .words(word_ch),
    .results(result_ch),
    .cfg(cfg_ch)
  );

  neuron_sum_tracker sb;
  bit sender_idle_on;
  bit sink_idle_on;
  bit calm;
  bit long_hold_req;
  int words_sent;
  int thresholds_written;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        sb.check_neuron(result_ch.neuron_sum, result_ch.neuron_value);
      end
      if (word_ch.valid && word_ch.ready) begin
        sb.take_word(word_ch.act_plus, word_ch.act_minus, word_ch.weight_plus,
                     word_ch.weight_minus, word_ch.last_word);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.set_threshold(cfg_ch.threshold);
      end
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        result_ch.ready = 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else if (sink_idle_on && !calm && $urandom_range(0, 5) == 0) begin
        result_ch.ready = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  function automatic void build_word(input word_mix_t mix, output mask_t ap, output mask_t am,
                                     output mask_t wp, output mask_t wm);
    case (mix)
      MIX_SPARSE: begin
        ap = $urandom & $urandom & $urandom;
        am = $urandom & $urandom & $urandom;
        wp = $urandom & $urandom & $urandom;
        wm = $urandom & $urandom & $urandom;
      end
      MIX_PROPER: begin
        ap = $urandom;
        am = $urandom & ~ap;
        wp = $urandom;
        wm = $urandom & ~wp;
      end
      MIX_AGREE: begin
        ap = $urandom;
        am = ~ap;
        wp = ap;
        wm = am;
      end
      MIX_DISAGREE: begin
        ap = $urandom;
        am = ~ap;
        wp = am;
        wm = ap;
      end
      default: begin
        ap = $urandom;
        am = $urandom;
        wp = $urandom;
        wm = $urandom;
      end
    endcase
  endfunction

  task automatic send_word(mask_t ap, mask_t am, mask_t wp, mask_t wm, logic last);
    if (sender_idle_on && !calm && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      word_ch.valid = 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk);
    end
    @(negedge clk);
    word_ch.act_plus = ap;
    word_ch.act_minus = am;
    word_ch.weight_plus = wp;
    word_ch.weight_minus = wm;
    word_ch.last_word = last;
    word_ch.valid = 1'b1;
    @(posedge clk);
    while (!word_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_neuron(int len, bit long_run);
    mask_t     ap, am, wp, wm;
    word_mix_t mix;
    bit        lean_agree;
    lean_agree = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if (long_run && $urandom_range(0, 4) != 0) begin
        mix = lean_agree ? MIX_AGREE : MIX_DISAGREE;
      end else begin
        mix = word_mix_t'($urandom_range(0, 4));
      end
      build_word(mix, ap, am, wp, wm);
      send_word(ap, am, wp, wm, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    word_ch.valid = 1'b0;
    while (sb.pending_neurons.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(int t);
    wait_drained();
    @(negedge clk);
    cfg_ch.threshold = tnp_pkg::thr_t'(t);
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    thresholds_written++;
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(0, 5))
      0: return SUM_BOUND;
      1: return -SUM_BOUND;
      2: return 0;
      3: return $urandom_range(0, 64);
      4: return -int'($urandom_range(0, 64));
      default: return int'($urandom_range(0, 2 * SUM_BOUND)) - SUM_BOUND;
    endcase
  endfunction

  initial begin
    #(TIMEOUT_NS);
    $display("timeout after %0d ns", TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int phase;
    int waited;
    sb = new();
    rst = 1'b1;
    word_ch.valid = 1'b0;
    word_ch.act_plus = '0;
    word_ch.act_minus = '0;
    word_ch.weight_plus = '0;
    word_ch.weight_minus = '0;
    word_ch.last_word = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.threshold = '0;
    sender_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    words_sent = 0;
    thresholds_written = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_threshold(5);
    send_word('0, '0, '0, '0, 1'b1);
    send_word('1, '0, '1, '0, 1'b1);
    send_word('1, '0, '0, '1, 1'b1);
    send_word('1, '1, '1, '0, 1'b1);
    send_word('1, '0, '1, '1, 1'b1);
    send_word('1, '1, '1, '1, 1'b1);
    send_word(32'h0000_FFFF, '0, 32'h0000_FFFF, '0, 1'b1);
    send_word(32'h0000_0001, '0, 32'h0000_0001, '0, 1'b1);
    send_word(32'h8000_0000, '0, '0, 32'h8000_0000, 1'b1);
    send_word('0, 32'h0000_00FF, 32'h0000_00FF, '0, 1'b1);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_word(32'hF0F0_F0F0, '0, '0, 32'hFFFF_0000, 1'b0);
    send_word('0, 32'h0F0F_0F0F, '0, 32'h0F0F_0F0F, 1'b0);
    send_word('0, '0, '0, '0, 1'b1);

    write_threshold(-3);
    send_word('0, '0, '0, '0, 1'b1);
    send_word(32'h0000_0003, '0, '0, 32'h0000_0003, 1'b1);
    send_word(32'h0000_03FF, '0, '0, 32'h0000_03FF, 1'b1);

    write_threshold(SUM_BOUND);
    send_word('1, '0, '1, '0, 1'b1);
    send_word('1, '0, '0, '1, 1'b1);

    write_threshold(-SUM_BOUND);
    send_word('0, '0, '0, '0, 1'b1);

    phase = 0;
    while (words_sent < RANDOM_WORDS) begin
      write_threshold(pick_threshold());
      calm = words_sent >= CALM_AFTER;
      sender_idle_on = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      if (phase == 3) begin
        long_hold_req = 1'b1;
        repeat (20) send_neuron($urandom_range(1, 2), 1'b0);
      end else begin
        repeat ($urandom_range(3, 12)) begin
          if ($urandom_range(0, 7) == 0) begin
            send_neuron($urandom_range(60, 100), 1'b1);
          end else begin
            send_neuron($urandom_range(1, 8), 1'b0);
          end
        end
      end
      phase++;
    end

    @(negedge clk);
    word_ch.valid = 1'b0;
    waited = 0;
    while (sb.pending_neurons.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending_neurons.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_neurons.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      repeat (10) @(posedge clk);
      $display("run: %0d words, %0d neuron results, %0d threshold writes over %0d phases",
               sb.words_seen, sb.results_seen, thresholds_written, phase);
      $display("run: %0d saturated accumulations, %0d mismatches", sb.clamp_count, sb.errors);
      if (sb.errors == 0 && sb.pending_neurons.size() == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
      $finish;
    end
  end

endmodule
